// ----- design/annexb_nal_splitter_merger_core_defines.svh -----
// Assertion macros used by the core design file.
`ifndef ANNEXB_NAL_SPLITTER_MERGER_CORE_DEFINES_SVH
`define ANNEXB_NAL_SPLITTER_MERGER_CORE_DEFINES_SVH

// Implication checked on every clock edge out of reset.
`define ANB_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Implication checked in the cycle after the antecedent.
`define ANB_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ----- design/anb_pkg.sv -----
`default_nettype none
package anb_pkg;
    localparam int UNIT_BUF_BYTES  = 65536;
    localparam int MERGE_BUF_BYTES = 262144;
    localparam int UA_W = $clog2(UNIT_BUF_BYTES);
    localparam int MA_W = $clog2(MERGE_BUF_BYTES);

    localparam logic [1:0] CMD_PUSH = 2'd0;
    localparam logic [1:0] CMD_RD_UNIT = 2'd1;
    localparam logic [1:0] CMD_RD_MERGE = 2'd2;
    localparam logic [1:0] CMD_RESTART = 2'd3;

    localparam logic [1:0] KIND_UNIT = 2'd0;
    localparam logic [1:0] KIND_MERGED = 2'd1;
    localparam logic [1:0] KIND_DATA = 2'd2;

    localparam logic [1:0] CFG_MODE = 2'd0;
    localparam logic [1:0] CFG_MIN = 2'd1;
    localparam logic [1:0] CFG_UPM = 2'd2;

    localparam logic [1:0] MODE_AUD = 2'd1;
    localparam logic [1:0] MODE_COUNT = 2'd2;

    localparam logic [4:0] TYPE_NON_IDR = 5'd1;
    localparam logic [4:0] TYPE_SPS = 5'd7;
    localparam logic [4:0] TYPE_PPS = 5'd8;
    localparam logic [4:0] TYPE_AUD = 5'd9;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [7:0]  data_byte;
        logic [17:0] read_index;
    } t_in;

    typedef struct packed {
        logic [1:0]  kind;
        logic [18:0] unit_length;
        logic [4:0]  unit_type;
        logic [7:0]  read_data;
        logic        merge_overflow;
        logic        last;
    } t_out;

    // Unit memory port request.
    typedef struct packed {
        logic            we;
        logic [UA_W-1:0] addr;
        logic [7:0]      wdata;
    } t_ureq;

    // Merge memory port request.
    typedef struct packed {
        logic            we;
        logic [MA_W-1:0] addr;
        logic [7:0]      wdata;
    } t_mreq;
endpackage
`default_nettype wire

// ----- design/anb_unit_mem.sv -----
`default_nettype none
module anb_unit_mem (
    input  wire logic          i_clk,
    input  wire anb_pkg::t_ureq i_req,
    output logic [7:0]         o_rdata
);
    import anb_pkg::*;
    logic [7:0] r_mem [UNIT_BUF_BYTES];
    always_ff @(posedge i_clk) begin
        if (i_req.we) r_mem[i_req.addr] <= i_req.wdata;
        o_rdata <= r_mem[i_req.addr];
    end
endmodule
`default_nettype wire

// ----- design/anb_merge_mem.sv -----
`default_nettype none
module anb_merge_mem (
    input  wire logic          i_clk,
    input  wire anb_pkg::t_mreq i_req,
    output logic [7:0]         o_rdata
);
    import anb_pkg::*;
    logic [7:0] r_mem [MERGE_BUF_BYTES];
    always_ff @(posedge i_clk) begin
        if (i_req.we) r_mem[i_req.addr] <= i_req.wdata;
        o_rdata <= r_mem[i_req.addr];
    end
endmodule
`default_nettype wire

// ----- design/annexb_nal_splitter_merger_core.sv -----
// A push that closes a reported unit passes S_HDR and S_DEC before its result is registered;
// an appended unit holds the block in S_COPY, one byte copied per cycle through the unit
// memory read port; a due merged report goes via S_MHDR, held on a blocked output, to S_MREP.
// One push per cycle while idle with the output free; a read holds the block in S_RD for the
// registered memory read; a start code stalls input while unit slots 0..3 are rewritten.
// Reset (synchronous, active low): control and config regs reset; data regs, buffers kept.
`default_nettype none
`include "annexb_nal_splitter_merger_core_defines.svh"
module annexb_nal_splitter_merger_core (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_valid,
    output logic               o_stall,
    input  wire anb_pkg::t_in  i_data,
    output logic               o_valid,
    input  wire logic          i_stall,
    output anb_pkg::t_out      o_data,
    input  wire logic          i_cfg_we,
    input  wire logic [1:0]    i_cfg_index,
    input  wire logic [16:0]   i_cfg_data
);
    import anb_pkg::*;

    typedef enum logic [7:0] {
        S_IDLE  = 8'b00000001,
        S_RD    = 8'b00000010,  // wait for read data
        S_HDR   = 8'b00000100,  // fetch unit type from slot 4
        S_DEC   = 8'b00001000,  // decide
        S_COPY  = 8'b00010000,  // copy unit into merge buffer
        S_MHDR  = 8'b00100000,  // fetch merged type
        S_MREP  = 8'b01000000,  // report merged unit
        S_EMIT  = 8'b10000000   // deliver queued second result
    } t_state;

    t_state r_st, n_st;
    logic [1:0]  r_mode;
    logic [16:0] r_min;
    logic [4:0]  r_upm;
    logic [16:0] r_wp, n_wp;
    logic [1:0]  r_sc, n_sc;
    logic [18:0] r_ml, n_ml;
    logic [4:0]  r_mc, n_mc;
    logic [16:0] r_len, n_len;
    logic [4:0]  r_type, n_type;
    logic [16:0] r_cp, n_cp;
    logic [2:0]  r_scw, n_scw;     // start code slots still to rewrite
    logic        r_aud, n_aud;     // AUD report follows merged report
    logic        r_rsel, n_rsel;
    logic [18:0] r_mbase, n_mbase;
    logic        r_ov, n_ov;
    t_out        r_q, n_q;         // queued second result
    t_out        n_o;
    logic        n_ov_valid;
    t_ureq       w_ureq;
    t_mreq       w_mreq;
    logic [7:0]  w_urd, w_mrd;
    logic        w_acc, w_out_free;
    logic [4:0]  w_tgt;
    logic [16:0] w_wp1;

    anb_unit_mem  u_umem (.i_clk(i_clk), .i_req(w_ureq), .o_rdata(w_urd));
    anb_merge_mem u_mmem (.i_clk(i_clk), .i_req(w_mreq), .o_rdata(w_mrd));

    assign w_out_free = !o_valid || !i_stall;
    assign o_stall = !(r_st == S_IDLE && w_out_free && r_scw == 3'd0);
    assign w_acc = i_valid && !o_stall;
    assign w_tgt = (r_upm == 5'd0) ? 5'd1 : r_upm;
    assign w_wp1 = r_wp + 17'd1;

    always_comb begin
        n_st = r_st; n_wp = r_wp; n_sc = r_sc; n_ml = r_ml; n_mc = r_mc;
        n_len = r_len; n_type = r_type; n_cp = r_cp; n_scw = r_scw; n_aud = r_aud;
        n_rsel = r_rsel; n_mbase = r_mbase; n_ov = r_ov; n_q = r_q;
        n_o = '0; n_ov_valid = 1'b0;
        w_ureq = '0; w_mreq = '0;
        // Rewrite start code slots 0..3 in idle cycles after a detection.
        if (r_st == S_IDLE && r_scw != 3'd0) begin
            w_ureq.we = 1'b1;
            w_ureq.addr = UA_W'(3'd4 - r_scw);
            w_ureq.wdata = (r_scw == 3'd1) ? 8'd1 : 8'd0;
        end
        unique case (r_st)
            S_IDLE: begin
                if (r_scw != 3'd0) n_scw = r_scw - 3'd1;
                if (w_acc) begin
                    case (i_data.cmd)
                        CMD_PUSH: begin
                            w_ureq.we = 1'b1;
                            w_ureq.addr = r_wp[UA_W-1:0];
                            w_ureq.wdata = i_data.data_byte;
                            n_wp = (w_wp1 >= 17'(UNIT_BUF_BYTES - 1)) ? '0 : w_wp1;
                            if (r_sc < 2'd3) begin
                                n_sc = (i_data.data_byte == 8'd0) ? r_sc + 2'd1 : 2'd0;
                            end else begin
                                n_sc = 2'd0;
                                if (i_data.data_byte == 8'd1) begin
                                    n_scw = 3'd4;
                                    n_wp = 17'd4;
                                    if (w_wp1 >= 17'd4 && (r_wp + 17'd1 >= 17'd4)
                                        && ((w_wp1 >= 17'(UNIT_BUF_BYTES - 1)) == 1'b0)
                                        && (w_wp1 - 17'd4) >= r_min) begin
                                        n_len = w_wp1 - 17'd4;
                                        n_st = S_HDR;
                                    end
                                end
                            end
                        end
                        CMD_RD_UNIT: begin
                            w_ureq.addr = i_data.read_index[UA_W-1:0];
                            n_rsel = 1'b0;
                            n_ov = i_data.read_index >= 18'(UNIT_BUF_BYTES);
                            n_st = S_RD;
                        end
                        CMD_RD_MERGE: begin
                            w_mreq.addr = i_data.read_index[MA_W-1:0];
                            n_rsel = 1'b1;
                            n_ov = 1'b0;
                            n_st = S_RD;
                        end
                        default: begin
                            n_wp = 17'd4; n_sc = 2'd0; n_ml = '0; n_mc = '0;
                        end
                    endcase
                end
            end
            S_RD: begin
                n_o.kind = KIND_DATA;
                n_o.read_data = r_ov ? 8'd0 : (r_rsel ? w_mrd : w_urd);
                n_o.last = 1'b1;
                n_ov_valid = 1'b1;
                n_st = S_IDLE;
            end
            S_HDR: begin
                w_ureq.addr = UA_W'(4);
                n_st = S_DEC;
            end
            S_DEC: begin
                n_type = w_urd[4:0];
                n_cp = '0;
                n_st = S_IDLE;
                if (r_mode == MODE_AUD) begin
                    if (w_urd[4:0] == TYPE_SPS || w_urd[4:0] == TYPE_PPS) begin
                        n_o = '{KIND_UNIT, {2'b0, r_len}, w_urd[4:0], 8'd0, 1'b0, 1'b1};
                        n_ov_valid = 1'b1; n_ml = '0;
                    end else if (w_urd[4:0] == TYPE_AUD) begin
                        if (r_ml != '0) begin
                            n_aud = 1'b1; n_st = S_MHDR;
                        end
                    end else if (w_urd[4:0] == TYPE_NON_IDR) begin
                        n_st = S_COPY;
                    end
                end else if (r_mode == MODE_COUNT) begin
                    if (w_urd[4:0] == TYPE_SPS || w_urd[4:0] == TYPE_PPS) begin
                        n_o = '{KIND_UNIT, {2'b0, r_len}, w_urd[4:0], 8'd0, 1'b0, 1'b1};
                        n_ov_valid = 1'b1;
                    end else begin
                        n_st = S_COPY;
                    end
                end else begin
                    n_o = '{KIND_UNIT, {2'b0, r_len}, w_urd[4:0], 8'd0, 1'b0, 1'b1};
                    n_ov_valid = 1'b1;
                end
                if (n_st == S_COPY) begin
                    n_mbase = r_ml;
                    if (20'(r_ml) + 20'(r_len) > 20'(MERGE_BUF_BYTES)) begin
                        n_ml = '0; n_mc = '0;
                        n_o = '{KIND_MERGED, 19'd0, 5'd0, 8'd0, 1'b1, 1'b1};
                        n_ov_valid = 1'b1;
                        n_st = S_IDLE;
                    end
                end
            end
            S_COPY: begin
                // Read byte r_cp; write byte r_cp-1 read the cycle before.
                // Slots 0..3 are not rewritten yet: write the start code directly.
                w_ureq.addr = r_cp[UA_W-1:0];
                if (r_cp != '0) begin
                    w_mreq.we = 1'b1;
                    w_mreq.addr = MA_W'(r_mbase + 19'(r_cp) - 19'd1);
                    if (r_cp <= 17'd4) w_mreq.wdata = (r_cp == 17'd4) ? 8'd1 : 8'd0;
                    else w_mreq.wdata = w_urd;
                end
                n_cp = r_cp + 17'd1;
                if (r_cp == r_len) begin
                    n_ml = r_mbase + 19'(r_len);
                    n_st = S_IDLE;
                    if (r_mode == MODE_COUNT) begin
                        n_mc = r_mc + 5'd1;
                        if (r_mc + 5'd1 >= w_tgt) n_st = S_MHDR;
                    end
                end
            end
            S_MHDR: begin
                w_mreq.addr = MA_W'(4);
                if (w_out_free) n_st = S_MREP;
            end
            S_MREP: begin
                n_o = '{KIND_MERGED, r_ml, w_mrd[4:0], 8'd0, 1'b0, !r_aud};
                n_ov_valid = 1'b1;
                n_ml = '0; n_mc = '0;
                n_q = '{KIND_UNIT, {2'b0, r_len}, r_type, 8'd0, 1'b0, 1'b1};
                n_st = r_aud ? S_EMIT : S_IDLE;
                n_aud = 1'b0;
            end
            S_EMIT: begin
                if (w_out_free) begin
                    n_o = r_q; n_ov_valid = 1'b1; n_st = S_IDLE;
                end
            end
            default: n_st = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= S_IDLE; r_wp <= 17'd4; r_sc <= '0; r_ml <= '0; r_mc <= '0;
            r_scw <= '0; r_aud <= 1'b0; r_mode <= '0; r_min <= 17'd4; r_upm <= 5'd4;
            o_valid <= 1'b0;
        end else begin
            r_st <= n_st; r_wp <= n_wp; r_sc <= n_sc; r_ml <= n_ml; r_mc <= n_mc;
            r_scw <= n_scw; r_aud <= n_aud;
            if (n_ov_valid) o_valid <= 1'b1;
            else if (!i_stall) o_valid <= 1'b0;
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_MODE: r_mode <= i_cfg_data[1:0];
                    CFG_MIN:  r_min <= i_cfg_data;
                    CFG_UPM:  r_upm <= i_cfg_data[4:0];
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_len <= n_len; r_type <= n_type; r_cp <= n_cp;
        r_rsel <= n_rsel; r_mbase <= n_mbase; r_ov <= n_ov; r_q <= n_q;
        if (n_ov_valid) o_data <= n_o;
    end

    `ANB_ASSERT_IMP(a_no_accept_busy, i_clk, i_rst_n, r_st != S_IDLE, o_stall)
    `ANB_ASSERT_IMP(a_wp_range, i_clk, i_rst_n, 1'b1, r_wp < 17'(UNIT_BUF_BYTES - 1))
    `ANB_ASSERT_IMP(a_ml_range, i_clk, i_rst_n, 1'b1, r_ml <= 19'(MERGE_BUF_BYTES))
    `ANB_ASSERT_NXT(a_rd_result, i_clk, i_rst_n, r_st == S_RD, o_valid)
endmodule
`default_nettype wire
